>>> design/dwps_pkg.sv
`timescale 1ns / 1ps

package dwps_pkg;

  localparam logic [1:0] MODE_WINDOW = 2'd0;
  localparam logic [1:0] MODE_RGB565 = 2'd1;
  localparam logic [1:0] MODE_GRAY   = 2'd2;
  localparam logic [1:0] MODE_BINARY = 2'd3;

  localparam logic [1:0] REG_ORIENTATION    = 2'd0;
  localparam logic [1:0] REG_GRAY_THRESHOLD = 2'd1;

  localparam logic [1:0] ORIENT_RESET = 2'd2;

  localparam logic [7:0] CMD_COLUMN_SET   = 8'h2a;
  localparam logic [7:0] CMD_ROW_SET      = 8'h2b;
  localparam logic [7:0] CMD_MEMORY_WRITE = 8'h2c;

  localparam logic [15:0] COLOR_WHITE = 16'hffff;
  localparam logic [15:0] COLOR_BLACK = 16'h0000;

  localparam logic [3:0] WINDOW_LAST_STEP = 4'd10;
  localparam logic [3:0] PIXEL_LAST_STEP  = 4'd1;

  typedef struct packed {
    logic        is_window;
    logic [7:0]  col_first;
    logic [7:0]  col_final;
    logic [7:0]  row_first;
    logic [7:0]  row_final;
    logic [15:0] color;
  } desc_t;

endpackage

>>> design/display_window_pixel_serializer.sv
`timescale 1ns / 1ps

// Channel        Handshake          Payload
// configuration  cfg_write          cfg_index, cfg_data
// request items  push / full        mode, x_start, y_start, x_end, y_end, pixel_value, swap_bytes
// byte items     empty / pop        out_byte, is_command, last
//
// The output register sends one byte per cycle while the receiver keeps popping, so a pixel item
// is two bytes and a window item eleven; that byte rate sets the throughput.
// An accepted item is first written into the request queue; its first byte is then loaded into the output register.
// Reset is synchronous and restores orientation to landscape and the threshold to zero.
// The request queue holds QUEUE_DEPTH classified items, so input stalls only when it fills.
module display_window_pixel_serializer
  import dwps_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  mode,
  input  logic [7:0]  x_start,
  input  logic [7:0]  y_start,
  input  logic [7:0]  x_end,
  input  logic [7:0]  y_end,
  input  logic [15:0] pixel_value,
  input  logic        swap_bytes,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        is_command,
  output logic        last
);

  desc_t front_desc;
  desc_t head_desc;
  logic  queue_empty;
  logic  queue_take;

  dwps_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mode        (mode),
    .x_start     (x_start),
    .y_start     (y_start),
    .x_end       (x_end),
    .y_end       (y_end),
    .pixel_value (pixel_value),
    .swap_bytes  (swap_bytes),
    .desc        (front_desc)
  );

  dwps_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push && !full),
    .wr_data (front_desc),
    .full    (full),
    .rd_en   (queue_take),
    .rd_data (head_desc),
    .empty   (queue_empty)
  );

  dwps_back u_back (
    .clk        (clk),
    .rst        (rst),
    .desc       (head_desc),
    .desc_empty (queue_empty),
    .desc_take  (queue_take),
    .empty      (empty),
    .pop        (pop),
    .out_byte   (out_byte),
    .is_command (is_command),
    .last       (last)
  );

endmodule

>>> design/dwps_front.sv
`timescale 1ns / 1ps

module dwps_front
  import dwps_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic [1:0]  mode,
  input  logic [7:0]  x_start,
  input  logic [7:0]  y_start,
  input  logic [7:0]  x_end,
  input  logic [7:0]  y_end,
  input  logic [15:0] pixel_value,
  input  logic        swap_bytes,
  output desc_t       desc
);

  logic [1:0] orientation;
  logic [7:0] gray_threshold;
  logic [7:0] col_off;
  logic [7:0] row_off;
  logic [7:0] gray;
  logic [15:0] color;

  always_ff @(posedge clk) begin
    if (rst) begin
      orientation <= ORIENT_RESET;
      gray_threshold <= 8'd0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ORIENTATION:    orientation <= cfg_data[1:0];
        REG_GRAY_THRESHOLD: gray_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // Portrait orientations shift columns by two and rows by one; landscape the reverse.
  assign col_off = orientation[1] ? 8'd1 : 8'd2;
  assign row_off = orientation[1] ? 8'd2 : 8'd1;
  assign gray = pixel_value[7:0];

  always_comb begin
    case (mode)
      MODE_RGB565: color = swap_bytes ? {pixel_value[7:0], pixel_value[15:8]} : pixel_value;
      MODE_GRAY: begin
        if (gray_threshold == 8'd0) begin
          color = {gray[7:3], gray[7:2], gray[7:3]};
        end else if (gray < gray_threshold) begin
          color = COLOR_BLACK;
        end else begin
          color = COLOR_WHITE;
        end
      end
      MODE_BINARY: color = pixel_value[0] ? COLOR_WHITE : COLOR_BLACK;
      default:     color = COLOR_BLACK;
    endcase
  end

  always_comb begin
    desc.is_window = (mode == MODE_WINDOW);
    desc.col_first = x_start + col_off;
    desc.col_final = x_end + col_off;
    desc.row_first = y_start + row_off;
    desc.row_final = y_end + row_off;
    desc.color = color;
  end

endmodule

>>> design/dwps_fifo.sv
`timescale 1ns / 1ps

module dwps_fifo
  import dwps_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  wr_en,
  input  desc_t wr_data,
  output logic  full,
  input  logic  rd_en,
  output desc_t rd_data,
  output logic  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  desc_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full = (count == CNT_FULL);
  assign empty = (count == '0);
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_MAX) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_MAX) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> design/dwps_back.sv
`timescale 1ns / 1ps

module dwps_back
  import dwps_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  desc_t      desc,
  input  logic       desc_empty,
  output logic       desc_take,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       is_command,
  output logic       last
);

  logic       out_valid;
  logic [3:0] step;
  logic       advance;
  logic       emit;
  logic [7:0] byte_next;
  logic       cmd_next;
  logic       last_next;

  assign empty = !out_valid;
  assign advance = !out_valid || pop;
  assign emit = advance && !desc_empty;
  assign desc_take = emit && last_next;

  always_comb begin
    byte_next = 8'h00;
    cmd_next = 1'b0;
    if (desc.is_window) begin
      last_next = (step == WINDOW_LAST_STEP);
      case (step)
        4'd0: begin
          byte_next = CMD_COLUMN_SET;
          cmd_next = 1'b1;
        end
        4'd2: byte_next = desc.col_first;
        4'd4: byte_next = desc.col_final;
        4'd5: begin
          byte_next = CMD_ROW_SET;
          cmd_next = 1'b1;
        end
        4'd7: byte_next = desc.row_first;
        4'd9: byte_next = desc.row_final;
        4'd10: begin
          byte_next = CMD_MEMORY_WRITE;
          cmd_next = 1'b1;
        end
        default: byte_next = 8'h00;
      endcase
    end else begin
      last_next = (step == PIXEL_LAST_STEP);
      byte_next = step[0] ? desc.color[7:0] : desc.color[15:8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      step <= 4'd0;
    end else if (advance) begin
      out_valid <= !desc_empty;
      if (emit) begin
        step <= last_next ? 4'd0 : step + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte <= byte_next;
      is_command <= cmd_next;
      last <= last_next;
    end
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import dwps_pkg::*;

  localparam logic [1:0] ORIENT_PORTRAIT       = 2'd0;
  localparam logic [1:0] ORIENT_PORTRAIT_FLIP  = 2'd1;
  localparam logic [1:0] ORIENT_LANDSCAPE      = 2'd2;
  localparam logic [1:0] ORIENT_LANDSCAPE_FLIP = 2'd3;
  localparam logic [1:0] REG_SPARE_LO = 2'd2;
  localparam logic [1:0] REG_SPARE_HI = 2'd3;

  localparam int SETTLE_CYCLES  = 6;
  localparam int RX_HOLD_CYCLES = 200;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  x_start;
    logic [7:0]  y_start;
    logic [7:0]  x_end;
    logic [7:0]  y_end;
    logic [15:0] pixel_value;
    logic        swap_bytes;
  } request_t;

  typedef struct packed {
    logic [7:0] data;
    logic       cmd;
    logic       fin;
  } link_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  mode = '0;
  logic [7:0]  x_start = '0;
  logic [7:0]  y_start = '0;
  logic [7:0]  x_end = '0;
  logic [7:0]  y_end = '0;
  logic [15:0] pixel_value = '0;
  logic        swap_bytes = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  out_byte;
  logic        is_command;
  logic        last;

  link_byte_t pending_bytes[$];
  logic [1:0] orient_model = ORIENT_RESET;
  logic [7:0] thresh_model = 8'd0;
  int errors = 0;
  int tx_idle_pct = 30;
  int rx_idle_pct = 30;
  bit rx_hold_start = 1'b0;
  int rx_hold_left = 0;
  int rx_gap_left = 0;
  int stuck_cycles = 0;

  display_window_pixel_serializer i_dut (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic int idle_gap(int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(40, 12);
    return $urandom_range(3, 1);
  endfunction

  function automatic request_t random_request(logic [1:0] m);
    request_t r;
    r.mode        = m;
    r.x_start     = 8'($urandom);
    r.y_start     = 8'($urandom);
    r.x_end       = 8'($urandom);
    r.y_end       = 8'($urandom);
    r.pixel_value = 16'($urandom);
    r.swap_bytes  = 1'($urandom);
    return r;
  endfunction

  function automatic request_t window_request(logic [7:0] xs, logic [7:0] ys,
                                              logic [7:0] xe, logic [7:0] ye);
    request_t r;
    r = random_request(MODE_WINDOW);
    r.x_start = xs;
    r.y_start = ys;
    r.x_end   = xe;
    r.y_end   = ye;
    return r;
  endfunction

  function automatic request_t pixel_request(logic [1:0] m, logic [15:0] value, logic swap);
    request_t r;
    r = random_request(m);
    r.pixel_value = value;
    r.swap_bytes  = swap;
    return r;
  endfunction

  task automatic expect_byte(logic [7:0] data, logic cmd, logic fin);
    link_byte_t b;
    b.data = data;
    b.cmd  = cmd;
    b.fin  = fin;
    pending_bytes.push_back(b);
  endtask

  task automatic serialize_request(request_t r);
    logic [7:0]  col_off;
    logic [7:0]  row_off;
    logic [7:0]  gray;
    logic [15:0] color;
    if (r.mode == MODE_WINDOW) begin
      if (orient_model == ORIENT_PORTRAIT || orient_model == ORIENT_PORTRAIT_FLIP) begin
        col_off = 8'd2;
        row_off = 8'd1;
      end else begin
        col_off = 8'd1;
        row_off = 8'd2;
      end
      expect_byte(CMD_COLUMN_SET, 1'b1, 1'b0);
      expect_byte(8'h00, 1'b0, 1'b0);
      expect_byte(8'(r.x_start + col_off), 1'b0, 1'b0);
      expect_byte(8'h00, 1'b0, 1'b0);
      expect_byte(8'(r.x_end + col_off), 1'b0, 1'b0);
      expect_byte(CMD_ROW_SET, 1'b1, 1'b0);
      expect_byte(8'h00, 1'b0, 1'b0);
      expect_byte(8'(r.y_start + row_off), 1'b0, 1'b0);
      expect_byte(8'h00, 1'b0, 1'b0);
      expect_byte(8'(r.y_end + row_off), 1'b0, 1'b0);
      expect_byte(CMD_MEMORY_WRITE, 1'b1, 1'b1);
    end else begin
      gray = r.pixel_value[7:0];
      case (r.mode)
        MODE_RGB565: begin
          color = r.swap_bytes ? {r.pixel_value[7:0], r.pixel_value[15:8]} : r.pixel_value;
        end
        MODE_GRAY: begin
          if (thresh_model == 8'd0) color = {gray[7:3], gray[7:2], gray[7:3]};
          else if (gray < thresh_model) color = COLOR_BLACK;
          else color = COLOR_WHITE;
        end
        default: begin
          color = r.pixel_value[0] ? COLOR_WHITE : COLOR_BLACK;
        end
      endcase
      expect_byte(color[15:8], 1'b0, 1'b0);
      expect_byte(color[7:0], 1'b0, 1'b1);
    end
  endtask

  task automatic send_request(request_t r);
    int gap;
    push        <= 1'b1;
    mode        <= r.mode;
    x_start     <= r.x_start;
    y_start     <= r.y_start;
    x_end       <= r.x_end;
    y_end       <= r.y_end;
    pixel_value <= r.pixel_value;
    swap_bytes  <= r.swap_bytes;
    do @(posedge clk); while (full !== 1'b0);
    serialize_request(r);
    gap = idle_gap(tx_idle_pct);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_ORIENTATION:    orient_model = data[1:0];
      REG_GRAY_THRESHOLD: thresh_model = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Reset state is landscape with gray converted to RGB565.
  task automatic test_reset_defaults();
    send_request(window_request(8'd0, 8'd0, 8'd255, 8'd255));
    send_request(window_request(8'd254, 8'd253, 8'd1, 8'd128));
    send_request(pixel_request(MODE_GRAY, 16'h0000, 1'b1));
    send_request(pixel_request(MODE_GRAY, 16'hab_ff, 1'b0));
  endtask

  task automatic test_orientations();
    logic [1:0] orients[4];
    orients = '{ORIENT_PORTRAIT, ORIENT_PORTRAIT_FLIP, ORIENT_LANDSCAPE,
                 ORIENT_LANDSCAPE_FLIP};
    foreach (orients[k]) begin
      wait_drained();
      write_reg(REG_ORIENTATION, {6'($urandom), orients[k]});
      send_request(window_request(8'd255, 8'd255, 8'd0, 8'd254));
    end
  endtask

  task automatic test_pixel_formats();
    send_request(pixel_request(MODE_RGB565, 16'h0000, 1'b0));
    send_request(pixel_request(MODE_RGB565, 16'hffff, 1'b1));
    send_request(pixel_request(MODE_RGB565, 16'ha55a, 1'b1));
    send_request(pixel_request(MODE_RGB565, 16'h1234, 1'b0));
    send_request(pixel_request(MODE_BINARY, 16'hfffe, 1'b1));
    send_request(pixel_request(MODE_BINARY, 16'h0001, 1'b0));
    wait_drained();
    write_reg(REG_GRAY_THRESHOLD, 8'd1);
    send_request(pixel_request(MODE_GRAY, 16'hff00, 1'b1));
    send_request(pixel_request(MODE_GRAY, 16'h0001, 1'b0));
    wait_drained();
    write_reg(REG_GRAY_THRESHOLD, 8'd255);
    send_request(pixel_request(MODE_GRAY, 16'h00fe, 1'b0));
    send_request(pixel_request(MODE_GRAY, 16'h80ff, 1'b1));
    wait_drained();
    write_reg(REG_SPARE_LO, 8'hff);
    write_reg(REG_SPARE_HI, 8'h00);
    send_request(pixel_request(MODE_GRAY, 16'h5a80, 1'b1));
  endtask

  // The receiver stops long enough for the block to fill and hold off its input.
  task automatic test_backpressure();
    wait_drained();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    rx_hold_start = 1'b1;
    repeat (40) send_request(random_request(2'($urandom)));
    wait_drained();
  endtask

  task automatic test_random_traffic();
    logic [7:0] thresh;
    for (int phase = 0; phase < 6; phase++) begin
      wait_drained();
      case (phase)
        0: thresh = 8'd0;
        1: thresh = 8'd255;
        2: thresh = 8'd1;
        3: thresh = 8'd0;
        default: thresh = 8'($urandom);
      endcase
      write_reg(REG_ORIENTATION, 8'($urandom));
      write_reg(REG_GRAY_THRESHOLD, thresh);
      tx_idle_pct = (phase == 2) ? 0 : $urandom_range(60, 10);
      rx_idle_pct = (phase == 2 || phase == 4) ? 0 : $urandom_range(60, 10);
      repeat (80) send_request(random_request(2'($urandom)));
    end
  endtask

  always @(posedge clk) begin
    link_byte_t exp_byte;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (pending_bytes.size() == 0) begin
          $error("unexpected item: out_byte %h is_command %b last %b",
                 out_byte, is_command, last);
          errors++;
        end else begin
          exp_byte = pending_bytes.pop_front();
          if (out_byte !== exp_byte.data) begin
            $error("out_byte: expected %h, got %h", exp_byte.data, out_byte);
            errors++;
          end
          if (is_command !== exp_byte.cmd) begin
            $error("is_command: expected %b, got %b", exp_byte.cmd, is_command);
            errors++;
          end
          if (last !== exp_byte.fin) begin
            $error("last: expected %b, got %b", exp_byte.fin, last);
            errors++;
          end
        end
      end
      if (rx_hold_start) begin
        rx_hold_left = RX_HOLD_CYCLES;
        rx_hold_start = 1'b0;
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        pop <= 1'b0;
      end else if (rx_gap_left > 0) begin
        rx_gap_left--;
        pop <= 1'b0;
      end else begin
        rx_gap_left = idle_gap(rx_idle_pct);
        pop <= (rx_gap_left == 0);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_write || (push && !full) || (pop && !empty)) stuck_cycles = 0;
    else stuck_cycles++;
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_orientations();
    test_pixel_formats();
    test_backpressure();
    test_random_traffic();
    wait_drained();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/dwps_pkg.sv
design/dwps_front.sv
design/dwps_fifo.sv
design/dwps_back.sv
design/display_window_pixel_serializer.sv
tb/tb.sv
